@@ hw/rtl/scrc_pkg.sv @@
// types, constants and step functions for the stick calibration datapath
`default_nettype none
package scrc_pkg;

  localparam int unsigned RAW_W  = 12;
  localparam int unsigned Q_W    = 15;
  localparam int unsigned NUM_W  = 23;
  localparam int unsigned SQ_W   = 30;
  localparam int unsigned M_W    = 31;
  localparam int unsigned N_W    = 52;
  localparam int unsigned P_W    = 56;
  localparam int unsigned T_W    = 43;
  localparam int unsigned R_W    = 11;

  localparam logic [Q_W-1:0]   SAT_LIMIT = 15'h7FFF;
  localparam logic [M_W-1:0]   RADIUS_SQ = 31'd4190209;
  localparam logic [RAW_W-1:0] SPAN_MIN  = 12'h001;

  // steps of the span division in each divider stage
  localparam int unsigned DIV_STEPS = 3;
  localparam int unsigned DIV_ST    = Q_W / DIV_STEPS;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_X_NEG_SPAN = 3'd2,
    REG_X_POS_SPAN = 3'd3,
    REG_Y_NEG_SPAN = 3'd4,
    REG_Y_POS_SPAN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [NUM_W-1:0] rem;
    logic [RAW_W-1:0] span;
    logic [Q_W-1:0]   q;
  } div_t;

  typedef struct packed {
    logic            neg;
    logic [Q_W-1:0]  a;
    logic [SQ_W-1:0] sq;
    logic [N_W-1:0]  n;
  } mid_ax_t;

  typedef struct packed {
    logic           clamp;
    logic [M_W-1:0] m;
    mid_ax_t        ax_x;
    mid_ax_t        ax_y;
  } mid_t;

  typedef struct packed {
    logic           neg;
    logic [Q_W-1:0] a;
    logic [N_W-1:0] n;
    logic [P_W-1:0] p;
    logic [T_W-1:0] t;
    logic [R_W-1:0] r;
  } rt_ax_t;

  typedef struct packed {
    logic           clamp;
    logic [M_W-1:0] m;
    rt_ax_t         ax_x;
    rt_ax_t         ax_y;
  } rt_t;

  // one restoring division step at quotient bit k
  function automatic div_t div_step(div_t s, int unsigned k);
    logic [26:0] dv;
    dv = {15'b0, s.span} << k;
    if ({4'b0, s.rem} >= dv) begin
      s.rem = s.rem - dv[NUM_W-1:0];
      s.q   = s.q | (Q_W'(1) << k);
    end
    return s;
  endfunction

  // one root bit: keeps p = r*r*m and t = r*m, tests (r + 2^k)^2 * m <= n
  function automatic rt_ax_t root_step(rt_ax_t s, logic [M_W-1:0] m, int unsigned k);
    logic [P_W-1:0] cand;
    cand = s.p + ({13'b0, s.t} << (k + 1)) + ({25'b0, m} << (2 * k));
    if (cand <= {4'b0, s.n}) begin
      s.p = cand;
      s.t = s.t + T_W'({12'b0, m} << k);
      s.r = s.r | (R_W'(1) << k);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/stick_calibrate_radial_clamp.sv @@
// top level: stick calibration with span scaling and radial clamp
// Calibrates a raw 12-bit stick pair: subtracts the center, scales each axis by
// 2047/span (span picked by sign, truncated, saturated to +/-32767), and when the
// radius exceeds 2047 pulls both axes onto the circle with exact integer math.
// One item is accepted per clock unless the output stalls; the pipeline has one
// input stage, five divider stages of three quotient bits, three square and
// scale stages, eleven root stages of one result bit, and the output register.
// Configuration writes are taken at any time but must only be made while idle.
`default_nettype none
module stick_calibrate_radial_clamp
  import scrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // raw_x[11:0], raw_y[23:12]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // out_x[11:0], out_y[23:12]
);

  localparam int unsigned ST_D0  = 1;
  localparam int unsigned ST_M1  = ST_D0 + DIV_ST;
  localparam int unsigned ST_R0  = ST_M1 + 3;
  localparam int unsigned ST_OUT = ST_R0 + R_W;
  localparam int unsigned NST    = ST_OUT + 1;

  logic [RAW_W-1:0] center_x_r, center_y_r;
  logic [RAW_W-1:0] x_neg_r, x_pos_r, y_neg_r, y_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= 12'd2048;
      center_y_r <= 12'd2048;
      x_neg_r    <= 12'd1024;
      x_pos_r    <= 12'd1024;
      y_neg_r    <= 12'd1024;
      y_pos_r    <= 12'd1024;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:   center_x_r <= cfg_wdata;
        REG_CENTER_Y:   center_y_r <= cfg_wdata;
        REG_X_NEG_SPAN: x_neg_r    <= cfg_wdata;
        REG_X_POS_SPAN: x_pos_r    <= cfg_wdata;
        REG_Y_NEG_SPAN: y_neg_r    <= cfg_wdata;
        REG_Y_POS_SPAN: y_pos_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid/ready chain, a stage loads when it is empty or its successor moves
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= (i == 0) ? in_tvalid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_tready = rdy[0];

  // input stage: center offset, span select (zero as one), numerator mag*2047
  function automatic div_t axis_in(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] ctr,
                                   logic [RAW_W-1:0] sn, logic [RAW_W-1:0] sp);
    logic [RAW_W:0]   d;
    logic [RAW_W-1:0] mag;
    logic [RAW_W-1:0] span;
    div_t             s;
    d    = {1'b0, raw} - {1'b0, ctr};
    mag  = d[RAW_W] ? RAW_W'(-d) : d[RAW_W-1:0];
    span = d[RAW_W] ? sn : sp;
    if (span == '0) begin
      span = SPAN_MIN;
    end
    s.neg  = d[RAW_W];
    s.sat  = 1'b0;
    s.rem  = ({11'b0, mag} << 11) - {11'b0, mag};
    s.span = span;
    s.q    = '0;
    return s;
  endfunction

  div_t s0x_r, s0y_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0x_r <= axis_in(in_tdata[11:0], center_x_r, x_neg_r, x_pos_r);
      s0y_r <= axis_in(in_tdata[23:12], center_y_r, y_neg_r, y_pos_r);
    end
  end

  // divider stages
  div_t dx_r [DIV_ST];
  div_t dy_r [DIV_ST];

  for (genvar j = 0; j < DIV_ST; j++) begin : g_div
    div_t sx, sy;
    always_comb begin
      if (j == 0) begin
        sx     = s0x_r;
        sy     = s0y_r;
        sx.sat = {4'b0, sx.rem} >= {sx.span, 15'b0};
        sy.sat = {4'b0, sy.rem} >= {sy.span, 15'b0};
      end else begin
        sx = dx_r[(j == 0) ? 0 : j - 1];
        sy = dy_r[(j == 0) ? 0 : j - 1];
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
        sx = div_step(sx, Q_W - 1 - j * DIV_STEPS - s);
        sy = div_step(sy, Q_W - 1 - j * DIV_STEPS - s);
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[ST_D0+j]) begin
        dx_r[j] <= sx;
        dy_r[j] <= sy;
      end
    end
  end

  // square, sum, compare with the radius and scale by 2047 twice
  mid_t m1_r, m2_r, m3_r;
  mid_t m1_nxt, m2_nxt, m3_nxt;

  function automatic mid_ax_t sq_in(div_t d);
    mid_ax_t o;
    o.neg = d.neg;
    o.a   = d.sat ? SAT_LIMIT : d.q;
    o.sq  = {15'b0, o.a} * {15'b0, o.a};
    o.n   = '0;
    return o;
  endfunction

  always_comb begin
    m1_nxt       = '0;
    m1_nxt.ax_x  = sq_in(dx_r[DIV_ST-1]);
    m1_nxt.ax_y  = sq_in(dy_r[DIV_ST-1]);

    m2_nxt        = m1_r;
    m2_nxt.m      = {1'b0, m1_r.ax_x.sq} + {1'b0, m1_r.ax_y.sq};
    m2_nxt.ax_x.n = ({22'b0, m1_r.ax_x.sq} << 11) - {22'b0, m1_r.ax_x.sq};
    m2_nxt.ax_y.n = ({22'b0, m1_r.ax_y.sq} << 11) - {22'b0, m1_r.ax_y.sq};

    m3_nxt        = m2_r;
    m3_nxt.clamp  = m2_r.m > RADIUS_SQ;
    m3_nxt.ax_x.n = (m2_r.ax_x.n << 11) - m2_r.ax_x.n;
    m3_nxt.ax_y.n = (m2_r.ax_y.n << 11) - m2_r.ax_y.n;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_M1])   m1_r <= m1_nxt;
    if (rdy[ST_M1+1]) m2_r <= m2_nxt;
    if (rdy[ST_M1+2]) m3_r <= m3_nxt;
  end

  // root stages, one result bit per stage for both axes
  rt_t r_r [R_W];

  for (genvar j = 0; j < R_W; j++) begin : g_root
    rt_t s;
    always_comb begin
      if (j == 0) begin
        s.clamp    = m3_r.clamp;
        s.m        = m3_r.m;
        s.ax_x.neg = m3_r.ax_x.neg;
        s.ax_x.a   = m3_r.ax_x.a;
        s.ax_x.n   = m3_r.ax_x.n;
        s.ax_x.p   = '0;
        s.ax_x.t   = '0;
        s.ax_x.r   = '0;
        s.ax_y.neg = m3_r.ax_y.neg;
        s.ax_y.a   = m3_r.ax_y.a;
        s.ax_y.n   = m3_r.ax_y.n;
        s.ax_y.p   = '0;
        s.ax_y.t   = '0;
        s.ax_y.r   = '0;
      end else begin
        s = r_r[(j == 0) ? 0 : j - 1];
      end
      s.ax_x = root_step(s.ax_x, s.m, R_W - 1 - j);
      s.ax_y = root_step(s.ax_y, s.m, R_W - 1 - j);
    end
    always_ff @(posedge clk) begin
      if (rdy[ST_R0+j]) begin
        r_r[j] <= s;
      end
    end
  end

  // output register: pick clamped or direct value and restore the sign
  function automatic logic [RAW_W-1:0] axis_out(rt_ax_t s, logic clamp);
    logic [Q_W:0] v;
    v = clamp ? {5'b0, s.r} : {1'b0, s.a};
    if (s.neg) begin
      v = -v;
    end
    return v[RAW_W-1:0];
  endfunction

  logic [23:0] out_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_r <= {axis_out(r_r[R_W-1].ax_y, r_r[R_W-1].clamp),
                axis_out(r_r[R_W-1].ax_x, r_r[R_W-1].clamp)};
    end
  end

  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

@@ hw/rtl/scrc_checker.sv @@
// port-level checks for the stick calibration block
`default_nettype none
module scrc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // results stay inside -2047..2047
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:0] != 12'h800)
    else $error("out_x outside range");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:12] != 12'h800)
    else $error("out_y outside range");

  // empty output means the whole pipeline can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind stick_calibrate_radial_clamp scrc_checker u_scrc_checker (.*);
`default_nettype wire

@@ sim/stick_calibrate_radial_clamp_tb.sv @@
// testbench for the stick calibration block: directed table, random items, self-checking
`timescale 1ns / 100ps
`default_nettype none
module stick_calibrate_radial_clamp_tb;
  import scrc_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned LATENCY    = 21;
  localparam int unsigned N_RANDOM   = 1500;

  typedef struct {
    logic [11:0] rx;
    logic [11:0] ry;
    logic        known;
    logic [11:0] ex;
    logic [11:0] ey;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  logic [11:0] cal_reg [6];
  logic [23:0] pos_q [$];
  int          errors;
  int          idle_cycles;
  bit          timed_out;

  stick_calibrate_radial_clamp i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint scale_axis(logic [11:0] raw, logic [11:0] ctr,
                                        logic [11:0] neg, logic [11:0] pos);
    longint d;
    longint unsigned span;
    longint unsigned q;
    d = longint'(raw) - longint'(ctr);
    span = (d < 0) ? neg : pos;
    if (span == 0) span = 1;
    q = ((d < 0) ? -d : d) * 2047 / span;
    if (q > 32767) q = 32767;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint pull_in(longint v, longint unsigned m);
    longint unsigned a;
    longint unsigned q;
    a = (v < 0) ? -v : v;
    q = int_sqrt(a * a * 2047 * 2047 / m);
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [23:0] calibrate(logic [11:0] rx, logic [11:0] ry);
    longint x;
    longint y;
    longint unsigned m;
    logic [11:0] ox;
    logic [11:0] oy;
    x = scale_axis(rx, cal_reg[REG_CENTER_X], cal_reg[REG_X_NEG_SPAN], cal_reg[REG_X_POS_SPAN]);
    y = scale_axis(ry, cal_reg[REG_CENTER_Y], cal_reg[REG_Y_NEG_SPAN], cal_reg[REG_Y_POS_SPAN]);
    m = x * x + y * y;
    if (m > 64'd4190209) begin
      x = pull_in(x, m);
      y = pull_in(y, m);
    end
    ox = x[11:0];
    oy = y[11:0];
    return {oy, ox};
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [11:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    cal_reg[idx] = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(logic [11:0] cx, logic [11:0] cy, logic [11:0] xn,
                           logic [11:0] xp, logic [11:0] yn, logic [11:0] yp);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_X_NEG_SPAN, xn);
    write_reg(REG_X_POS_SPAN, xp);
    write_reg(REG_Y_NEG_SPAN, yn);
    write_reg(REG_Y_POS_SPAN, yp);
  endtask

  // no gap over half the time, most others short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(logic [11:0] rx, logic [11:0] ry, logic [23:0] exp_pos);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ry, rx};
    pos_q.push_back(exp_pos);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pos_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [11:0] rand_raw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'h000;
    if (r == 1) return 12'hFFF;
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [11:0] rand_span();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'h000;
    if (r == 1) return 12'h001;
    if (r == 2) return 12'hFFF;
    return 12'($urandom_range(1, 4095));
  endfunction

  // output side: random stalls and comparison against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pos_q.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, out_tdata);
          errors++;
        end else begin
          if (out_tdata[11:0] !== pos_q[0][11:0])
            $display("%0t: out_x mismatch, expected %h actual %h", $time,
                     pos_q[0][11:0], out_tdata[11:0]);
          if (out_tdata[23:12] !== pos_q[0][23:12])
            $display("%0t: out_y mismatch, expected %h actual %h", $time,
                     pos_q[0][23:12], out_tdata[23:12]);
          if (out_tdata !== pos_q[0]) errors++;
          void'(pos_q.pop_front());
        end
      end
      out_tready <= (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      timed_out = 1'b1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t dir [$];
    row_t rw;
    logic [23:0] ep;
    errors = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cal_reg[REG_CENTER_X] = 12'd2048;
    cal_reg[REG_CENTER_Y] = 12'd2048;
    cal_reg[REG_X_NEG_SPAN] = 12'd1024;
    cal_reg[REG_X_POS_SPAN] = 12'd1024;
    cal_reg[REG_Y_NEG_SPAN] = 12'd1024;
    cal_reg[REG_Y_POS_SPAN] = 12'd1024;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: center gives zero, a full positive span gives 2047
    dir = '{
      '{12'd2048, 12'd2048, 1'b1, 12'd0,    12'd0},
      '{12'd3072, 12'd2048, 1'b1, 12'd2047, 12'd0},
      '{12'd1024, 12'd2048, 1'b1, 12'h801,  12'd0},
      '{12'd2048, 12'd3072, 1'b1, 12'd0,    12'd2047},
      '{12'd2048, 12'd1024, 1'b1, 12'd0,    12'h801},
      '{12'd4095, 12'd2048, 1'b1, 12'd2047, 12'd0},
      '{12'd0,    12'd2048, 1'b1, 12'h801,  12'd0},
      '{12'd4095, 12'd4095, 1'b0, 12'd0,    12'd0},
      '{12'd0,    12'd0,    1'b0, 12'd0,    12'd0},
      '{12'd0,    12'd4095, 1'b0, 12'd0,    12'd0},
      '{12'd3000, 12'd1500, 1'b0, 12'd0,    12'd0},
      '{12'd2049, 12'd2047, 1'b0, 12'd0,    12'd0}
    };
    foreach (dir[i]) begin
      rw = dir[i];
      ep = rw.known ? {rw.ey, rw.ex} : calibrate(rw.rx, rw.ry);
      send(rw.rx, rw.ry, ep);
    end
    drain();

    // span of zero acts as one, and saturation to 32767 before the clamp
    write_all(12'd0, 12'd4095, 12'd0, 12'd0, 12'd1, 12'd0);
    send(12'd4095, 12'd4095, calibrate(12'd4095, 12'd4095));
    send(12'd1, 12'd4094, calibrate(12'd1, 12'd4094));
    send(12'd0, 12'd0, calibrate(12'd0, 12'd0));
    send(12'd0, 12'd4095, {12'd0, 12'd0});
    drain();
    write_all(12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send(12'd0, 12'd4095, calibrate(12'd0, 12'd4095));
    send(12'd4095, 12'd0, calibrate(12'd4095, 12'd0));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_all(rand_raw(), rand_raw(), rand_span(), rand_span(), rand_span(), rand_span());
      for (int n = 0; n < N_RANDOM / 10; n++) begin
        logic [11:0] rx;
        logic [11:0] ry;
        rx = rand_raw();
        ry = rand_raw();
        send(rx, ry, calibrate(rx, ry));
      end
      drain();
    end

    if (errors == 0 && pos_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
